### design/itar_pkg.sv
// Shared constants and helpers for the integer to ASCII converter.
package itar_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int RADIX_W       = 5;
	localparam int DIGIT_W       = 4;
	localparam int CH_W          = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

	localparam logic [CH_W-1:0]    ASCII_ZERO  = 7'h30;
	localparam logic [CH_W-1:0]    ASCII_MINUS = 7'h2D;
	localparam logic [CH_W-1:0]    ASCII_NONE  = 7'h00;
	localparam logic [CH_W-1:0]    ALPHA_GAP   = 7'd7;
	localparam logic [DIGIT_W-1:0] DEC_TOP     = 4'd9;

	function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
		return (r >= RADIX_MIN) && (r <= RADIX_MAX);
	endfunction

	// digit value to '0'..'9' / 'A'..'F'
	function automatic logic [CH_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CH_W-1:0] c;
		c = {{(CH_W-DIGIT_W){1'b0}}, d} + ASCII_ZERO;
		if (d > DEC_TOP) begin
			c = c + ALPHA_GAP;
		end
		return c;
	endfunction

endpackage

### design/integer_to_ascii_radix.sv
// Top level: signed integer to ASCII text in a configurable base (2 to 16).
//
//  channel | handshake              | payload                 | direction
//  --------+------------------------+-------------------------+----------
//  input   | in_valid / in_stall    | value                   | in
//  output  | out_valid / out_stall  | ch, last, invalid       | out
//  config  | cfg_valid / cfg_ready  | cfg_radix               | in
//
// One request at a time. The magnitude is divided by the radix in one shared
// bit-serial divider, one digit per division; each character then passes
// through memory read, output load and output, and the '-', when present,
// through a sign load and output. An invalid radix goes straight to output.
// Reset sets radix to 10 and idles the sequencer; digit store contents are
// don't-care. A stalled output holds the sequencer; the input is stalled
// whenever a request is in progress.
module integer_to_ascii_radix #(
	parameter int WORD_BITS = itar_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request in
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [WORD_BITS-1:0]  value,
	// characters out
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [itar_pkg::CH_W-1:0]    ch,
	output logic                         last,
	output logic                         invalid,
	// radix register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [itar_pkg::RADIX_W-1:0] cfg_radix
);
	import itar_pkg::*;

	localparam int AW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_BITS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_SIGN = 6'b000100,
		S_RD   = 6'b001000,
		S_LOAD = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     count_q;
	logic                 sign_q;
	logic [CH_W-1:0]      ch_q;
	logic                 last_q;
	logic                 invalid_q;

	logic                 in_take;
	logic                 neg;
	logic [WORD_BITS-1:0] value_u;
	logic [WORD_BITS-1:0] magnitude;

	// divider hookup
	logic                 div_start;
	logic [WORD_BITS-1:0] div_dividend;
	logic                 div_done;
	logic [WORD_BITS-1:0] div_quo;
	logic [DIGIT_W-1:0]   div_rem;

	// digit store hookup
	logic                 mem_wr;
	logic                 mem_rd;
	logic [CNT_W-1:0]     count_dec;
	logic [DIGIT_W-1:0]   mem_data;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// two's complement magnitude; the most negative value maps to 2^(W-1)
	assign value_u   = value;
	assign neg       = value_u[WORD_BITS-1];
	assign magnitude = neg ? (~value_u + 1'b1) : value_u;

	// start on a fresh request, or chain straight on with the last quotient
	assign div_start    = (in_take && radix_ok(radix_q)) ||
	                      (state_q == S_DIV && div_done && div_quo != '0 &&
	                       count_q < CNT_MAX - 1'b1);
	assign div_dividend = (state_q == S_IDLE) ? magnitude : div_quo;

	assign mem_wr    = (state_q == S_DIV) && div_done;
	assign mem_rd    = (state_q == S_RD);
	assign count_dec = count_q - 1'b1;

	itar_div #(.WORD_BITS(WORD_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (radix_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	itar_dmem #(.DEPTH(WORD_BITS)) u_dmem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (div_rem),
		.rd_en   (mem_rd),
		.rd_addr (count_dec[AW-1:0]),
		.rd_data (mem_data)
	);

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_radix;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sign_q    <= 1'b0;
			last_q    <= 1'b0;
			invalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (radix_ok(radix_q)) begin
							count_q <= '0;
							sign_q  <= neg && (radix_q == RADIX_DEC);
							state_q <= S_DIV;
						end else begin
							// bad radix: one flagged result, nothing else
							last_q    <= 1'b1;
							invalid_q <= 1'b1;
							state_q   <= S_OUT;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q <= count_q + 1'b1;
						if (!div_start) begin
							state_q <= sign_q ? S_SIGN : S_RD;
						end
					end
				end
				S_SIGN: begin
					sign_q    <= 1'b0;
					last_q    <= 1'b0;
					invalid_q <= 1'b0;
					state_q   <= S_OUT;
				end
				S_RD: begin
					count_q <= count_dec;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					last_q    <= (count_q == '0);
					invalid_q <= 1'b0;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= last_q ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// character register, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_take && !radix_ok(radix_q)) begin
			ch_q <= ASCII_NONE;
		end else if (state_q == S_SIGN) begin
			ch_q <= ASCII_MINUS;
		end else if (state_q == S_LOAD) begin
			ch_q <= digit_to_ascii(mem_data);
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign ch        = ch_q;
	assign last      = last_q;
	assign invalid   = invalid_q;

	// an invalid result is always the only one
	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> last)
		else $error("invalid result without last");

	// digit count never runs past the word width
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("digit count overflow");

	// a read always has a stored digit behind it
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> count_q != '0)
		else $error("digit read from empty store");

	// a good-radix request goes straight into division
	a_take_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && radix_ok(radix_q) |=> state_q == S_DIV)
		else $error("request did not start division");

endmodule

### design/itar_div.sv
// Bit-serial restoring divider: word by radix, one quotient bit per cycle.
module itar_div #(
	parameter int WORD_BITS = itar_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WORD_BITS-1:0]         dividend,
	input  logic [itar_pkg::RADIX_W-1:0] divisor,
	output logic                         done,
	output logic [WORD_BITS-1:0]         quotient,
	output logic [itar_pkg::DIGIT_W-1:0] remainder
);
	import itar_pkg::*;

	localparam int STEP_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic                 done_q;

	logic [RADIX_W-1:0]   rem_sh;
	logic                 fits;
	logic [RADIX_W-1:0]   rem_diff;
	logic [DIGIT_W-1:0]   rem_nx;

	// remainder stays below divisor (<= 16), so it fits in a digit
	assign rem_sh   = {rem_q, quo_q[WORD_BITS-1]};
	assign fits     = rem_sh >= divisor;
	assign rem_diff = rem_sh - divisor;
	assign rem_nx   = fits ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LAST;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### design/itar_dmem.sv
// Digit store: one write port, one registered read port.
module itar_dmem #(
	parameter int DEPTH = itar_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [itar_pkg::DIGIT_W-1:0]     wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [itar_pkg::DIGIT_W-1:0]     rd_data
);
	import itar_pkg::*;

	logic [DIGIT_W-1:0] mem_q [DEPTH];
	logic [DIGIT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### sim/itar_text_checker.sv
// Channel monitor for the integer to ASCII converter: predicts each number's text and checks it.
module itar_text_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [31:0]                  value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [itar_pkg::CH_W-1:0]    ch,
	input  logic                         last,
	input  logic                         invalid,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [itar_pkg::RADIX_W-1:0] cfg_radix,
	output int                           chars_due,
	output int                           mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import itar_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
		logic            invalid;
	} text_char_t;

	text_char_t         text_q[$];
	text_char_t         want;
	logic [RADIX_W-1:0] radix_now;
	int                 errors;

	// Appends the characters that one number turns into under the given base.
	function automatic void spell_value(input logic [31:0] v, input logic [RADIX_W-1:0] base);
		logic [31:0]        mag;
		logic [31:0]        rem;
		logic [DIGIT_W-1:0] digits [32];
		logic [CH_W-1:0]    c;
		int                 n;
		text_char_t         t;
		if (base < RADIX_MIN || base > RADIX_MAX) begin
			t.ch      = ASCII_NONE;
			t.last    = 1'b1;
			t.invalid = 1'b1;
			text_q.push_back(t);
			return;
		end
		// two's complement magnitude; the most negative word maps to 2^31
		mag = v[31] ? (~v + 32'd1) : v;
		n = 0;
		do begin
			rem = mag % {27'd0, base};
			digits[n] = rem[DIGIT_W-1:0];
			mag = mag / {27'd0, base};
			n++;
		end while (mag != 32'd0 && n < 32);
		if (v[31] && base == RADIX_DEC) begin
			t.ch      = ASCII_MINUS;
			t.last    = 1'b0;
			t.invalid = 1'b0;
			text_q.push_back(t);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c = ASCII_ZERO + {3'd0, digits[i]};
			if (digits[i] > DEC_TOP) begin
				c = c + ALPHA_GAP;
			end
			t.ch      = c;
			t.last    = (i == 0);
			t.invalid = 1'b0;
			text_q.push_back(t);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q.delete();
			radix_now = RADIX_RESET;
			errors = 0;
			chars_due <= 0;
			mismatches <= 0;
		end else begin
			// results leave before a new request can add to the queue
			if (out_valid && !out_stall) begin
				if (text_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected char: got ch=%02h last=%0b invalid=%0b",
							$time, ch, last, invalid);
					end
				end else begin
					want = text_q.pop_front();
					if (want.ch !== ch || want.last !== last || want.invalid !== invalid) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: char wrong: want ch=%02h last=%0b invalid=%0b, %s",
								$time, want.ch, want.last, want.invalid,
								$sformatf("got ch=%02h last=%0b invalid=%0b",
									ch, last, invalid));
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				spell_value(value, radix_now);
			end
			if (cfg_valid && cfg_ready) begin
				radix_now = cfg_radix;
			end
			chars_due <= text_q.size();
			mismatches <= errors;
		end
	end

endmodule

### sim/tb_integer_to_ascii_radix.sv
// Stimulus and verdict for the integer to ASCII converter.
module tb_integer_to_ascii_radix;
	timeunit 1ns;
	timeprecision 1ps;
	import itar_pkg::*;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [31:0]        value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CH_W-1:0]    ch;
	logic               last;
	logic               invalid;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;

	int                 chars_due;
	int                 mismatches;

	// chance, in percent, that the sender idles / the receiver stalls in a cycle
	int unsigned        tx_idle_pct  = 0;
	int unsigned        rx_stall_pct = 0;

	// 125 MHz
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	integer_to_ascii_radix i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ch        (ch),
		.last      (last),
		.invalid   (invalid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_radix (cfg_radix)
	);

	itar_text_checker i_text_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ch        (ch),
		.last      (last),
		.invalid   (invalid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_radix (cfg_radix),
		.chars_due (chars_due),
		.mismatches(mismatches)
	);

	// Receiver back-pressure: independent of out_valid, redrawn every cycle.
	always @(posedge clk) begin
		out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct  <= 0;
				rx_stall_pct <= 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct  <= 52;
				rx_stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct  <= 0;
				rx_stall_pct <= 52;
			end
			default: begin
				tx_idle_pct  <= 17;
				rx_stall_pct <= 17;
			end
		endcase
	endtask

	// One request: hold value steady until the block takes it, then maybe idle.
	// Called at a rising edge; in_valid is only ever assigned once per step.
	task automatic send_value(input logic [31:0] v);
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// Stop sending and wait until every predicted character has been seen.
	// chars_due is registered in the checker, so it trails the last accepted
	// request and is only read after waiting on the clock.
	task automatic drain_text();
		in_valid <= 1'b0;
		do @(posedge clk); while (chars_due != 0);
	endtask

	// Radix changes only with the converter idle.
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		drain_text();
		cfg_valid <= 1'b1;
		cfg_radix <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly full-range words so every bit toggles; some short numbers and the
	// corner words so digit counts spread out.
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(9))
			5, 6:    v = $urandom_range(999);
			7:       v = 32'd0 - $urandom_range(999);
			8: begin
				case ($urandom_range(3))
					0:       v = 32'h0000_0000;
					1:       v = 32'hFFFF_FFFF;
					2:       v = 32'h8000_0000;
					default: v = 32'h7FFF_FFFF;
				endcase
			end
			9:       v = $urandom() >> $urandom_range(31);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [RADIX_W-1:0] phase_radix(input int p);
		case (p)
			0:       return RADIX_DEC;
			1:       return RADIX_MIN;
			2:       return RADIX_MAX;
			3:       return RADIX_W'($urandom_range(2, 16));
			4:       return RADIX_W'($urandom_range(0, 31));
			5:       return 5'd8;
			6:       return RADIX_W'($urandom_range(3, 15));
			default: return RADIX_DEC;
		endcase
	endfunction

	// Run limit: worst case is ~32 digits, each divided bit by bit, plus stalled
	// characters per request; 20 ms is several times the slowest clean run.
	initial begin
		#20_000_000;
		$display("integer_to_ascii_radix: mismatch");
		$finish;
	end

	initial begin
		int pause_at;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. Reset radix is decimal: sign handling,
		// zero, both word extremes.
		set_idling(IDLE_NONE);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd0 - 32'd10);
		send_value(32'd123456789);

		// hex: letters A-F, negatives print as bare magnitude
		write_radix(RADIX_MAX);
		send_value(32'h00AB_CDEF);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'd0);

		// binary: most negative word gives the full 32 digits
		write_radix(RADIX_MIN);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'hFFFF_FFFF);
		send_value(32'd5);

		// bases outside 2..16 answer with a single invalid flag
		write_radix(5'd0);
		send_value(32'd42);
		write_radix(5'd1);
		send_value(32'h8000_0000);
		write_radix(5'd17);
		send_value(32'd7);
		write_radix(5'd31);
		send_value(32'd0 - 32'd5);

		// Random part: phases cycle through the idling modes, each with its
		// own radix and one extra full drain at a random point.
		for (int p = 0; p < 8; p++) begin
			write_radix(phase_radix(p));
			set_idling(idle_mode_t'(p % 4));
			pause_at = $urandom_range(24);
			for (int k = 0; k < 25; k++) begin
				if (k == pause_at) begin
					drain_text();
				end
				send_value(pick_value());
			end
		end

		drain_text();
		// trailing window: anything more from the block would be spurious
		repeat (40) @(posedge clk);

		if (mismatches == 0 && chars_due == 0) begin
			$display("integer_to_ascii_radix: match");
		end else begin
			$display("integer_to_ascii_radix: mismatch");
		end
		$finish;
	end

endmodule
